// ===== sv/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Types, codes and helpers shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int WIDTH = 32;

  localparam logic [3:0] KIND_MAKE = 4'd0;
  localparam logic [3:0] KIND_ADD  = 4'd1;
  localparam logic [3:0] KIND_SUB  = 4'd2;
  localparam logic [3:0] KIND_MUL  = 4'd3;
  localparam logic [3:0] KIND_DIV  = 4'd4;
  localparam logic [3:0] KIND_NEG  = 4'd5;
  localparam logic [3:0] KIND_EQ   = 4'd6;
  localparam logic [3:0] KIND_NE   = 4'd7;
  localparam logic [3:0] KIND_ISZ  = 4'd8;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // magnitude of the most negative value
  localparam logic [WIDTH-1:0] MINMAG = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic [2*WIDTH-1:0] MAXPOS2 = {{(WIDTH+1){1'b0}}, {(WIDTH-1){1'b1}}};

  typedef struct packed {
    logic [3:0]              kind;
    logic signed [WIDTH-1:0] a_num;
    logic signed [WIDTH-1:0] a_den;
    logic signed [WIDTH-1:0] b_num;
    logic signed [WIDTH-1:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [WIDTH-1:0] res_num;
    logic signed [WIDTH-1:0] res_den;
    logic                    truth;
    logic [1:0]              status;
  } out_item_t;

  typedef struct packed {
    logic             neg;
    logic [WIDTH-1:0] mag;
  } sval_t;

  typedef struct packed {
    logic      imm;
    out_item_t imm_res;
    logic [3:0] kind;
    sval_t     an;
    sval_t     ad;
    sval_t     bn;
    sval_t     bd;
  } work_t;

  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] n_mag;
    logic [WIDTH-1:0] d_mag;
  } red_req_t;

  typedef struct packed {
    logic             done;
    logic [WIDTH-1:0] n_mag;
    logic [WIDTH-1:0] d_mag;
  } red_rsp_t;

  function automatic sval_t from_bits(logic [WIDTH-1:0] v);
    sval_t s;
    s.neg = v[WIDTH-1];
    s.mag = v[WIDTH-1] ? WIDTH'(~v + 1'b1) : v;
    return s;
  endfunction

  function automatic logic [WIDTH-1:0] to_bits(sval_t s);
    return s.neg ? WIDTH'(~s.mag + 1'b1) : s.mag;
  endfunction

  function automatic logic fits2(logic neg, logic [2*WIDTH-1:0] mag);
    logic nneg;
    nneg = neg && (mag != '0);
    return nneg ? (mag <= MAXPOS2 + 1'b1) : (mag <= MAXPOS2);
  endfunction

endpackage

// ===== sv/rational_arithmetic_unit.sv =====
// Is-zero, bad kinds and zero denominators need no arithmetic; compares take
// two shift-add products; make and negate take up to two gcd reductions, the other
// arithmetic kinds up to three, with two products for multiply and divide and three
// for add and subtract. The back end carries out one request at a time;
// front and queue keep taking requests meanwhile.
// Reset (rst_n low, synchronous) empties the queue and the result register.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact signed fraction arithmetic with gcd reduction and compare.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  rau_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output rau_pkg::out_item_t out_item
);

  logic              q_push, q_full, q_pop, q_empty;
  rau_pkg::work_t    q_din, q_dout;
  rau_pkg::red_req_t red_req;
  rau_pkg::red_rsp_t red_rsp;

  rau_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_push  (q_push),
    .q_din   (q_din),
    .q_full  (q_full)
  );

  rau_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  rau_reduce u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (red_req),
    .rsp   (red_rsp)
  );

  rau_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_dout    (q_dout),
    .red_req   (red_req),
    .red_rsp   (red_rsp),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.status != rau_pkg::ST_OK |->
      out_item.res_num == '0 && out_item.res_den == '0 && !out_item.truth)
    else $error("error result carries a value");

  a_truth_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.truth |-> out_item.res_num == '0 && out_item.res_den == '0)
    else $error("compare result carries a fraction");

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue both full and empty");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("back end popped an empty queue");

endmodule

// ===== sv/rau_front.sv =====
// ----------------------------------------------------------------------------
// rau_front
// Takes requests, splits operands into sign and magnitude and settles the
// kinds that need no arithmetic.
// ----------------------------------------------------------------------------
module rau_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  rau_pkg::in_item_t in_item,
  output logic              q_push,
  output rau_pkg::work_t    q_din,
  input  logic              q_full
);

  logic           valid_r;
  rau_pkg::work_t work_r, work_nxt;
  logic           take;
  logic           uses_b;
  logic           zden;

  assign in_full = valid_r && q_full;
  assign take    = in_push && !in_full;
  assign q_push  = valid_r && !q_full;
  assign q_din   = work_r;

  always_comb begin
    work_nxt.kind = in_item.kind;
    work_nxt.an   = rau_pkg::from_bits(in_item.a_num);
    work_nxt.ad   = rau_pkg::from_bits(in_item.a_den);
    work_nxt.bn   = rau_pkg::from_bits(in_item.b_num);
    work_nxt.bd   = rau_pkg::from_bits(in_item.b_den);
    uses_b = in_item.kind inside {rau_pkg::KIND_ADD, rau_pkg::KIND_SUB, rau_pkg::KIND_MUL,
                                  rau_pkg::KIND_DIV, rau_pkg::KIND_EQ, rau_pkg::KIND_NE};
    zden = (work_nxt.ad.mag == '0) || (uses_b && work_nxt.bd.mag == '0) ||
           (in_item.kind == rau_pkg::KIND_DIV && work_nxt.bn.mag == '0);
    work_nxt.imm     = 1'b0;
    work_nxt.imm_res = '0;
    if (in_item.kind > rau_pkg::KIND_ISZ) begin
      work_nxt.imm = 1'b1;
    end else if (zden) begin
      work_nxt.imm            = 1'b1;
      work_nxt.imm_res.status = rau_pkg::ST_ZDEN;
    end else if (in_item.kind == rau_pkg::KIND_ISZ) begin
      work_nxt.imm           = 1'b1;
      work_nxt.imm_res.truth = (work_nxt.an.mag == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (q_push) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      work_r <= work_nxt;
    end
  end

endmodule

// ===== sv/rau_fifo.sv =====
// ----------------------------------------------------------------------------
// rau_fifo
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module rau_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rau_pkg::work_t din,
  output logic           full,
  input  logic           pop,
  output rau_pkg::work_t dout,
  output logic           empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rau_pkg::work_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/rau_reduce.sv =====
// ----------------------------------------------------------------------------
// rau_reduce
// Reduces a numerator/denominator magnitude pair: binary gcd one step per
// cycle, then two restoring divisions side by side, one bit per cycle.
// ----------------------------------------------------------------------------
module rau_reduce (
  input  logic               clk,
  input  logic               rst_n,
  input  rau_pkg::red_req_t  req,
  output rau_pkg::red_rsp_t  rsp
);

  localparam int W  = rau_pkg::WIDTH;
  localparam int KW = $clog2(W);
  localparam int CW = $clog2(W + 1);

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_GCD  = 3'b010,
    R_DIV  = 3'b100
  } rstate_t;

  rstate_t       state_r;
  logic [W-1:0]  u_r, v_r, g_r, qn_r, qd_r, g_c;
  logic [W:0]    remn_r, remd_r, shn, shd;
  logic [KW-1:0] k_r;
  logic [CW-1:0] cnt_r;
  logic          done_r;

  assign rsp.done  = done_r;
  assign rsp.n_mag = qn_r;
  assign rsp.d_mag = qd_r;

  assign g_c = (u_r | v_r) << k_r;
  assign shn = {remn_r[W-1:0], qn_r[W-1]};
  assign shd = {remd_r[W-1:0], qd_r[W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        R_IDLE: begin
          if (req.start) begin
            state_r <= R_GCD;
          end
        end
        R_GCD: begin
          if (u_r == '0 || v_r == '0) begin
            if (g_c == '0) begin
              done_r  <= 1'b1;
              state_r <= R_IDLE;
            end else begin
              state_r <= R_DIV;
            end
          end
        end
        R_DIV: begin
          if (cnt_r == CW'(1)) begin
            done_r  <= 1'b1;
            state_r <= R_IDLE;
          end
        end
        default: state_r <= R_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      R_IDLE: begin
        u_r  <= req.n_mag;
        v_r  <= req.d_mag;
        qn_r <= req.n_mag;
        qd_r <= req.d_mag;
        k_r  <= '0;
      end
      R_GCD: begin
        if (u_r == '0 || v_r == '0) begin
          g_r    <= g_c;
          remn_r <= '0;
          remd_r <= '0;
          cnt_r  <= CW'(W);
        end else if (!u_r[0] && !v_r[0]) begin
          u_r <= u_r >> 1;
          v_r <= v_r >> 1;
          k_r <= k_r + 1'b1;
        end else if (!u_r[0]) begin
          u_r <= u_r >> 1;
        end else if (!v_r[0]) begin
          v_r <= v_r >> 1;
        end else if (u_r >= v_r) begin
          u_r <= (u_r - v_r) >> 1;
        end else begin
          v_r <= (v_r - u_r) >> 1;
        end
      end
      R_DIV: begin
        if (shn >= {1'b0, g_r}) begin
          remn_r <= shn - {1'b0, g_r};
          qn_r   <= {qn_r[W-2:0], 1'b1};
        end else begin
          remn_r <= shn;
          qn_r   <= {qn_r[W-2:0], 1'b0};
        end
        if (shd >= {1'b0, g_r}) begin
          remd_r <= shd - {1'b0, g_r};
          qd_r   <= {qd_r[W-2:0], 1'b1};
        end else begin
          remd_r <= shd;
          qd_r   <= {qd_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/rau_back.sv =====
// ----------------------------------------------------------------------------
// rau_back
// Sequencer that carries out one request: operand reduction, shift-add
// products, sum or compare, final reduction, then the result register, as the kind needs.
// ----------------------------------------------------------------------------
module rau_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  output logic                q_pop,
  input  rau_pkg::work_t      q_dout,
  output rau_pkg::red_req_t   red_req,
  input  rau_pkg::red_rsp_t   red_rsp,
  output logic                out_empty,
  input  logic                out_pop,
  output rau_pkg::out_item_t  out_item
);

  localparam int W  = rau_pkg::WIDTH;
  localparam int CW = $clog2(W + 1);

  typedef enum logic [7:0] {
    B_IDLE   = 8'b0000_0001,
    B_RSTART = 8'b0000_0010,
    B_RED    = 8'b0000_0100,
    B_DISP   = 8'b0000_1000,
    B_MSTART = 8'b0001_0000,
    B_MUL    = 8'b0010_0000,
    B_OP     = 8'b0100_0000,
    B_DONE   = 8'b1000_0000
  } bstate_t;

  typedef enum logic [1:0] {
    SEL_A,
    SEL_B,
    SEL_R
  } sel_t;

  bstate_t state_r, state_nxt;
  sel_t    sel_r, sel_nxt;
  logic [3:0] kind_r, kind_nxt;
  rau_pkg::sval_t an_r, ad_r, bn_r, bd_r, rn_r, rd_r;
  rau_pkg::sval_t an_nxt, ad_nxt, bn_nxt, bd_nxt, rn_nxt, rd_nxt;
  rau_pkg::sval_t mx, my;
  logic [1:0] midx_r, midx_nxt, last_idx;
  logic [2*W-1:0] p_r [3];
  logic [2:0]     ps_r;
  logic [2*W-1:0] mcand_r, mcand_nxt, acc_r, acc_nxt, acc_step;
  logic [W-1:0]   mplier_r, mplier_nxt;
  logic           mneg_r, mneg_nxt;
  logic [CW-1:0]  mcnt_r, mcnt_nxt;
  logic           p_we;
  rau_pkg::out_item_t res_r, res_nxt, out_r, out_nxt;
  logic           outv_r, outv_nxt;
  logic           uses_b;

  // operation results
  logic           n0, n1, n2, f0, f1, f2, same, sneg, sfit, eqv, z1, z2;
  logic [W:0]     s;

  assign out_empty = !outv_r;
  assign out_item  = out_r;

  assign uses_b = kind_r inside {rau_pkg::KIND_ADD, rau_pkg::KIND_SUB, rau_pkg::KIND_MUL,
                                 rau_pkg::KIND_DIV, rau_pkg::KIND_EQ, rau_pkg::KIND_NE};
  assign last_idx = (kind_r == rau_pkg::KIND_ADD || kind_r == rau_pkg::KIND_SUB) ? 2'd2 : 2'd1;
  assign acc_step = mplier_r[0] ? acc_r + mcand_r : acc_r;

  // multiplier operands
  always_comb begin
    case (midx_r)
      2'd0: begin
        mx = an_r;
        my = (kind_r == rau_pkg::KIND_MUL) ? bn_r : bd_r;
      end
      2'd1: begin
        mx = ad_r;
        my = (kind_r == rau_pkg::KIND_MUL) ? bd_r : bn_r;
      end
      default: begin
        mx = ad_r;
        my = bd_r;
      end
    endcase
  end

  always_comb begin
    n0 = ps_r[0] && (p_r[0] != '0);
    n1 = ps_r[1] && (p_r[1] != '0);
    n2 = ps_r[2] && (p_r[2] != '0);
    f0 = rau_pkg::fits2(ps_r[0], p_r[0]);
    f1 = rau_pkg::fits2(ps_r[1], p_r[1]);
    f2 = rau_pkg::fits2(ps_r[2], p_r[2]);
    same = (n0 == n1);
    if (same) begin
      s    = {1'b0, p_r[0][W-1:0]} + {1'b0, p_r[1][W-1:0]};
      sneg = n0;
    end else if (p_r[0][W-1:0] >= p_r[1][W-1:0]) begin
      s    = {1'b0, p_r[0][W-1:0] - p_r[1][W-1:0]};
      sneg = n0;
    end else begin
      s    = {1'b0, p_r[1][W-1:0] - p_r[0][W-1:0]};
      sneg = n1;
    end
    sfit = rau_pkg::fits2(sneg, {{(W-1){1'b0}}, s});
    z1   = (an_r.mag == '0);
    z2   = (bn_r.mag == '0);
    eqv  = (z1 || z2) ? (z1 && z2) :
           (((an_r.neg ^ bd_r.neg) == (ad_r.neg ^ bn_r.neg)) && (p_r[0] == p_r[1]));
  end

  always_comb begin
    state_nxt  = state_r;
    sel_nxt    = sel_r;
    kind_nxt   = kind_r;
    an_nxt     = an_r;
    ad_nxt     = ad_r;
    bn_nxt     = bn_r;
    bd_nxt     = bd_r;
    rn_nxt     = rn_r;
    rd_nxt     = rd_r;
    midx_nxt   = midx_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    mneg_nxt   = mneg_r;
    mcnt_nxt   = mcnt_r;
    res_nxt    = res_r;
    out_nxt    = out_r;
    outv_nxt   = outv_r;
    p_we       = 1'b0;
    q_pop      = 1'b0;
    red_req.start = 1'b0;
    case (sel_r)
      SEL_A:   begin red_req.n_mag = an_r.mag; red_req.d_mag = ad_r.mag; end
      SEL_B:   begin red_req.n_mag = bn_r.mag; red_req.d_mag = bd_r.mag; end
      default: begin red_req.n_mag = rn_r.mag; red_req.d_mag = rd_r.mag; end
    endcase
    if (out_pop && outv_r) begin
      outv_nxt = 1'b0;
    end
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          kind_nxt = q_dout.kind;
          an_nxt   = q_dout.an;
          ad_nxt   = q_dout.ad;
          bn_nxt   = q_dout.bn;
          bd_nxt   = q_dout.bd;
          res_nxt  = q_dout.imm_res;
          midx_nxt = 2'd0;
          sel_nxt  = SEL_A;
          if (q_dout.imm) begin
            state_nxt = B_DONE;
          end else if (q_dout.kind == rau_pkg::KIND_EQ || q_dout.kind == rau_pkg::KIND_NE) begin
            state_nxt = B_MSTART;
          end else begin
            state_nxt = B_RSTART;
          end
        end
      end
      B_RSTART: begin
        red_req.start = 1'b1;
        state_nxt     = B_RED;
      end
      B_RED: begin
        if (red_rsp.done) begin
          case (sel_r)
            SEL_A:   begin an_nxt.mag = red_rsp.n_mag; ad_nxt.mag = red_rsp.d_mag; end
            SEL_B:   begin bn_nxt.mag = red_rsp.n_mag; bd_nxt.mag = red_rsp.d_mag; end
            default: begin rn_nxt.mag = red_rsp.n_mag; rd_nxt.mag = red_rsp.d_mag; end
          endcase
          state_nxt = B_DISP;
        end
      end
      B_DISP: begin
        res_nxt = '0;
        if (sel_r == SEL_A && uses_b) begin
          sel_nxt   = SEL_B;
          state_nxt = B_RSTART;
        end else if (sel_r == SEL_R) begin
          res_nxt.res_num = rau_pkg::to_bits(rn_r);
          res_nxt.res_den = rau_pkg::to_bits(rd_r);
          state_nxt       = B_DONE;
        end else begin
          case (kind_r)
            rau_pkg::KIND_MAKE: begin
              rn_nxt    = an_r;
              rd_nxt    = ad_r;
              sel_nxt   = SEL_R;
              state_nxt = B_RSTART;
            end
            rau_pkg::KIND_NEG: begin
              if (an_r.neg && an_r.mag == rau_pkg::MINMAG) begin
                res_nxt.status = rau_pkg::ST_OVF;
                state_nxt      = B_DONE;
              end else begin
                rn_nxt.neg = !an_r.neg && (an_r.mag != '0);
                rn_nxt.mag = an_r.mag;
                rd_nxt     = ad_r;
                sel_nxt    = SEL_R;
                state_nxt  = B_RSTART;
              end
            end
            rau_pkg::KIND_SUB: begin
              // a - b runs as a + (-b)
              if (bn_r.neg && bn_r.mag == rau_pkg::MINMAG) begin
                res_nxt.status = rau_pkg::ST_OVF;
                state_nxt      = B_DONE;
              end else begin
                bn_nxt.neg = !bn_r.neg && (bn_r.mag != '0);
                midx_nxt   = 2'd0;
                state_nxt  = B_MSTART;
              end
            end
            default: begin
              midx_nxt  = 2'd0;
              state_nxt = B_MSTART;
            end
          endcase
        end
      end
      B_MSTART: begin
        mcand_nxt  = {{W{1'b0}}, mx.mag};
        mplier_nxt = my.mag;
        acc_nxt    = '0;
        mneg_nxt   = mx.neg ^ my.neg;
        mcnt_nxt   = CW'(W);
        state_nxt  = B_MUL;
      end
      B_MUL: begin
        acc_nxt    = acc_step;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        mcnt_nxt   = mcnt_r - 1'b1;
        if (mcnt_r == CW'(1)) begin
          p_we = 1'b1;
          if (midx_r == last_idx) begin
            state_nxt = B_OP;
          end else begin
            midx_nxt  = midx_r + 1'b1;
            state_nxt = B_MSTART;
          end
        end
      end
      B_OP: begin
        res_nxt = '0;
        case (kind_r)
          rau_pkg::KIND_EQ, rau_pkg::KIND_NE: begin
            res_nxt.truth = (kind_r == rau_pkg::KIND_NE) ? !eqv : eqv;
            state_nxt     = B_DONE;
          end
          rau_pkg::KIND_MUL, rau_pkg::KIND_DIV: begin
            if (f0 && f1) begin
              rn_nxt    = '{neg: n0, mag: p_r[0][W-1:0]};
              rd_nxt    = '{neg: n1, mag: p_r[1][W-1:0]};
              sel_nxt   = SEL_R;
              state_nxt = B_RSTART;
            end else begin
              res_nxt.status = rau_pkg::ST_OVF;
              state_nxt      = B_DONE;
            end
          end
          default: begin
            if (f0 && f1 && f2 && sfit) begin
              rn_nxt    = '{neg: sneg && (s != '0), mag: s[W-1:0]};
              rd_nxt    = '{neg: n2, mag: p_r[2][W-1:0]};
              sel_nxt   = SEL_R;
              state_nxt = B_RSTART;
            end else begin
              res_nxt.status = rau_pkg::ST_OVF;
              state_nxt      = B_DONE;
            end
          end
        endcase
      end
      B_DONE: begin
        // hold until the result register frees up
        if (!outv_r || out_pop) begin
          out_nxt   = res_r;
          outv_nxt  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      outv_r  <= outv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r    <= sel_nxt;
    kind_r   <= kind_nxt;
    an_r     <= an_nxt;
    ad_r     <= ad_nxt;
    bn_r     <= bn_nxt;
    bd_r     <= bd_nxt;
    rn_r     <= rn_nxt;
    rd_r     <= rd_nxt;
    midx_r   <= midx_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
    mneg_r   <= mneg_nxt;
    mcnt_r   <= mcnt_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
    if (p_we) begin
      p_r[midx_r]  <= acc_step;
      ps_r[midx_r] <= mneg_r;
    end
  end

endmodule
